[design/rdzm_pkg.sv]
// ----------------------------------------------------------------------------
// rdzm_pkg
// Shared types and constants for the radial dead zone mapper.
// ----------------------------------------------------------------------------
package rdzm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int CFG_IDX_W   = 2;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER = 2'd1;

  typedef enum logic [1:0] {
    ZONE_DEAD   = 2'd0,
    ZONE_LINEAR = 2'd1,
    ZONE_FULL   = 2'd2
  } zone_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] raw_x;
    logic signed [SAMPLE_BITS-1:0] raw_y;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] corrected_x;
    logic signed [SAMPLE_BITS-1:0] corrected_y;
    logic [SAMPLE_BITS-1:0]        corrected_magnitude;
    zone_t                         zone;
  } result_t;

endpackage

[design/radial_dead_zone_mapper.sv]
// ----------------------------------------------------------------------------
// radial_dead_zone_mapper
// Radial scaled dead zone for a two-axis stick sample.
//
// usage: a stick sample word (raw_x, raw_y, signed Q1.15) enters on the sample
// channel (sample_valid / sample_ready) and one result word leaves on the
// result channel (result_valid / result_ready) for every sample, in order.
// the result carries the rescaled position, the mapped radius and a zone code.
// thresholds are written on the config port (cfg_we, cfg_index, cfg_data):
// index 0 inner radius, index 1 outer radius; other indexes are ignored.
// write them only while the pipeline is empty.
// throughput: one sample per clock while the output is not held. the bit-serial
// pipelines hold 24 square root stages, 17 stages for the radius mapping divide
// and 17 stages for the per-axis scaling divide, plus setup and output regs.
// all stages advance together; when the receiver holds off result_ready with
// a word waiting, the whole pipe freezes and sample_ready drops, nothing is
// lost or repeated. reset (rst, synchronous) empties the pipe and loads the
// thresholds with inner 0 and outer full scale.
// ----------------------------------------------------------------------------
module radial_dead_zone_mapper
  import rdzm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SAMPLE_BITS-1:0] cfg_data
);

  localparam int N   = SAMPLE_BITS;
  localparam int RB  = N + FRAC_BITS;      // radius width, 8 fraction bits
  localparam int RW  = 2 * RB;             // radicand width
  localparam int QB  = N + 1;              // quotient bits of both divides
  localparam int MDW = RB + N + 1;         // mapping dividend width
  localparam int ADW = 2 * N + 10;         // axis dividend width
  localparam int L   = 5 + RB + 2 * QB;    // pipeline depth

  localparam logic [N-1:0] FULL = N'(1) << (N - 1);

  // square root lane
  typedef struct packed {
    logic [RB+1:0] rem;
    logic [RB-1:0] root;
    logic [RW-1:0] val;
    logic [N-1:0]  ax;
    logic [N-1:0]  ay;
    logic          sx;
    logic          sy;
  } sq_t;

  // radius mapping divide lane
  typedef struct packed {
    logic [RB:0]   rem;
    logic [QB-1:0] low;
    logic [QB-1:0] q;
    logic [RB:0]   dv;
    logic [RB-1:0] rad;
    logic          fixed;
    logic [N-1:0]  fmag;
    zone_t         zone;
    logic [N-1:0]  ax;
    logic [N-1:0]  ay;
    logic          sx;
    logic          sy;
  } md_t;

  typedef struct packed {
    logic [2*N-1:0] px;
    logic [2*N-1:0] py;
    logic [RB-1:0]  rad;
    logic [N-1:0]   mag;
    zone_t          zone;
    logic           sx;
    logic           sy;
  } pr_t;

  // per-axis scaling divide, both axes side by side
  typedef struct packed {
    logic [RB:0]   remx;
    logic [QB-1:0] lowx;
    logic [QB-1:0] qx;
    logic [RB:0]   remy;
    logic [QB-1:0] lowy;
    logic [QB-1:0] qy;
    logic [RB:0]   dv;
    logic          zero;
    logic [N-1:0]  mag;
    zone_t         zone;
    logic          sx;
    logic          sy;
  } ad_t;

  // one restoring divide step: returns {quotient bit, new remainder}
  function automatic logic [RB+1:0] div_step(logic [RB:0] rem, logic bit_in,
                                             logic [RB:0] dv);
    logic [RB+1:0] sh;
    logic [RB+1:0] df;
    sh = {rem, bit_in};
    df = sh - {1'b0, dv};
    if (sh >= {1'b0, dv}) begin
      return {1'b1, df[RB:0]};
    end else begin
      return {1'b0, sh[RB:0]};
    end
  endfunction

  function automatic sq_t sq_step(sq_t s);
    sq_t           r;
    logic [RB+2:0] rem2;
    logic [RB+2:0] trial;
    r     = s;
    rem2  = {s.rem[RB:0], s.val[RW-1:RW-2]};
    trial = {1'b0, s.root, 2'b01};
    r.val = {s.val[RW-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = (RB+2)'(rem2 - trial);
      r.root = {s.root[RB-2:0], 1'b1};
    end else begin
      r.rem  = rem2[RB+1:0];
      r.root = {s.root[RB-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic md_t md_step(md_t s);
    md_t           r;
    logic [RB+1:0] st;
    r     = s;
    st    = div_step(s.rem, s.low[QB-1], s.dv);
    r.rem = st[RB:0];
    r.low = {s.low[QB-2:0], 1'b0};
    r.q   = {s.q[QB-2:0], st[RB+1]};
    return r;
  endfunction

  function automatic ad_t ad_step(ad_t s);
    ad_t           r;
    logic [RB+1:0] stx;
    logic [RB+1:0] sty;
    r      = s;
    stx    = div_step(s.remx, s.lowx[QB-1], s.dv);
    sty    = div_step(s.remy, s.lowy[QB-1], s.dv);
    r.remx = stx[RB:0];
    r.lowx = {s.lowx[QB-2:0], 1'b0};
    r.qx   = {s.qx[QB-2:0], stx[RB+1]};
    r.remy = sty[RB:0];
    r.lowy = {s.lowy[QB-2:0], 1'b0};
    r.qy   = {s.qy[QB-2:0], sty[RB+1]};
    return r;
  endfunction

  // signed result from an unsigned quotient, saturated to the field range
  function automatic logic [N-1:0] sat_axis(logic [QB-1:0] q, logic neg);
    logic [QB-1:0] lim;
    if (neg) begin
      lim = (q > QB'(FULL)) ? QB'(FULL) : q;
      return N'(QB'(0) - lim);
    end else begin
      lim = (q > QB'(FULL - 1'b1)) ? QB'(FULL - 1'b1) : q;
      return lim[N-1:0];
    end
  endfunction

  logic [N-1:0] inner_threshold;
  logic [N-1:0] outer_threshold;
  logic [L-1:0] vld;
  logic         en;

  // input stage registers
  logic [N-1:0]   p1_ax;
  logic [N-1:0]   p1_ay;
  logic           p1_sx;
  logic           p1_sy;
  logic [2*N-1:0] p1_sqx;
  logic [2*N-1:0] p1_sqy;

  sq_t     sq [RB];
  md_t     md [QB+1];
  pr_t     pr;
  ad_t     ad [QB+1];
  result_t res;

  // absolute values at the input
  logic [N-1:0] in_ax;
  logic [N-1:0] in_ay;

  // mapping setup
  sq_t           sq_fin;
  sq_t           sq_init;
  md_t           md_init;
  logic [RB-1:0] in8;
  logic [RB-1:0] out8;
  logic [RB-1:0] rad_m;
  logic [MDW-1:0] mdiv;

  // product and axis setup
  md_t           md_fin;
  logic [N-1:0]  mag_sel;
  ad_t           ad_init;
  logic [ADW-1:0] dvx;
  logic [ADW-1:0] dvy;
  ad_t           ad_fin;

  // whole pipe moves unless a finished word is held at the output
  assign en           = !vld[L-1] || result_ready;
  assign sample_ready = en;
  assign result_valid = vld[L-1];
  assign result       = res;

  assign in_ax = sample.raw_x[N-1] ? N'(-sample.raw_x) : sample.raw_x;
  assign in_ay = sample.raw_y[N-1] ? N'(-sample.raw_y) : sample.raw_y;

  // start of the square root: radicand = (x^2 + y^2) << 16
  always_comb begin
    sq_init      = '0;
    sq_init.val  = {p1_sqx + p1_sqy, (2 * FRAC_BITS)'(0)};
    sq_init.ax   = p1_ax;
    sq_init.ay   = p1_ay;
    sq_init.sx   = p1_sx;
    sq_init.sy   = p1_sy;
  end

  // zone decision and setup of the radius mapping divide
  always_comb begin
    sq_fin  = sq[RB-1];
    rad_m   = sq_fin.root;
    in8     = {inner_threshold, FRAC_BITS'(0)};
    out8    = {outer_threshold, FRAC_BITS'(0)};
    mdiv    = {rad_m - in8, N'(0)} + MDW'(out8 - in8);
    md_init = '0;
    md_init.rem   = (RB+1)'(mdiv[MDW-1:QB]);
    md_init.low   = mdiv[QB-1:0];
    md_init.dv    = {out8 - in8, 1'b0};
    md_init.rad   = rad_m;
    md_init.ax    = sq_fin.ax;
    md_init.ay    = sq_fin.ay;
    md_init.sx    = sq_fin.sx;
    md_init.sy    = sq_fin.sy;
    md_init.fixed = 1'b1;
    if (out8 <= in8) begin
      // degenerate thresholds: a plain step at outer
      if (rad_m >= out8) begin
        md_init.fmag = FULL;
        md_init.zone = ZONE_FULL;
      end else begin
        md_init.fmag = '0;
        md_init.zone = ZONE_DEAD;
      end
    end else if (rad_m <= in8) begin
      md_init.fmag = '0;
      md_init.zone = ZONE_DEAD;
    end else if (rad_m >= out8) begin
      md_init.fmag = FULL;
      md_init.zone = ZONE_FULL;
    end else begin
      md_init.fixed = 1'b0;
      md_init.fmag  = '0;
      md_init.zone  = ZONE_LINEAR;
    end
  end

  always_comb begin
    md_fin  = md[QB];
    if (md_fin.fixed) begin
      mag_sel = md_fin.fmag;
    end else if (md_fin.q > QB'(FULL)) begin
      mag_sel = FULL;
    end else begin
      mag_sel = md_fin.q[N-1:0];
    end
  end

  // axis divide setup: (|c| * mag * 2^9 + rad) / (2 * rad)
  always_comb begin
    dvx          = {pr.px, 9'b0} + ADW'(pr.rad);
    dvy          = {pr.py, 9'b0} + ADW'(pr.rad);
    ad_init      = '0;
    ad_init.remx = dvx[ADW-1:QB];
    ad_init.lowx = dvx[QB-1:0];
    ad_init.remy = dvy[ADW-1:QB];
    ad_init.lowy = dvy[QB-1:0];
    ad_init.dv   = {pr.rad, 1'b0};
    ad_init.zero = (pr.rad == '0);
    ad_init.mag  = pr.mag;
    ad_init.zone = pr.zone;
    ad_init.sx   = pr.sx;
    ad_init.sy   = pr.sy;
    ad_fin       = ad[QB];
  end

  // control: valid chain and threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld             <= '0;
      inner_threshold <= '0;
      outer_threshold <= FULL;
    end else begin
      if (en) begin
        vld <= {vld[L-2:0], sample_valid};
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INNER: inner_threshold <= cfg_data;
          CFG_OUTER: outer_threshold <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      p1_ax  <= in_ax;
      p1_ay  <= in_ay;
      p1_sx  <= sample.raw_x[N-1];
      p1_sy  <= sample.raw_y[N-1];
      p1_sqx <= in_ax * in_ax;
      p1_sqy <= in_ay * in_ay;

      // one root bit per stage
      sq[0] <= sq_step(sq_init);
      for (int k = 1; k < RB; k++) begin
        sq[k] <= sq_step(sq[k-1]);
      end

      // one quotient bit per stage
      md[0] <= md_init;
      for (int k = 1; k <= QB; k++) begin
        md[k] <= md_step(md[k-1]);
      end

      pr.px   <= md_fin.ax * mag_sel;
      pr.py   <= md_fin.ay * mag_sel;
      pr.rad  <= md_fin.rad;
      pr.mag  <= mag_sel;
      pr.zone <= md_fin.zone;
      pr.sx   <= md_fin.sx;
      pr.sy   <= md_fin.sy;

      ad[0] <= ad_init;
      for (int k = 1; k <= QB; k++) begin
        ad[k] <= ad_step(ad[k-1]);
      end

      // zero radius gives the origin
      res.corrected_x         <= ad_fin.zero ? '0 : sat_axis(ad_fin.qx, ad_fin.sx);
      res.corrected_y         <= ad_fin.zero ? '0 : sat_axis(ad_fin.qy, ad_fin.sy);
      res.corrected_magnitude <= ad_fin.mag;
      res.zone                <= ad_fin.zone;
    end
  end

endmodule

[test/radial_dead_zone_mapper_checker.sv]
// ----------------------------------------------------------------------------
// radial_dead_zone_mapper_checker
// Watches the sample and result channels, predicts each result word from the
// accepted sample word and the current thresholds, and compares in order.
// ----------------------------------------------------------------------------
module radial_dead_zone_mapper_checker
  import rdzm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  input  logic                   sample_ready,
  input  sample_t                sample,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SAMPLE_BITS-1:0] cfg_data,
  output int                     errors,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned FS = 64'd1 << (SAMPLE_BITS - 1);

  logic [SAMPLE_BITS-1:0] inner_q, outer_q;
  result_t mapped_q[$];

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] scale_axis(longint c, longint unsigned mag,
                                                        longint unsigned rad);
    longint unsigned a, q;
    a = (c < 0) ? longint'(-c) : longint'(c);
    q = (a * mag * (64'd2 << FRAC_BITS) + rad) / (64'd2 * rad);
    if (c < 0) begin
      if (q > FS) q = FS;
      return SAMPLE_BITS'(-longint'(q));
    end
    if (q > FS - 1) q = FS - 1;
    return SAMPLE_BITS'(q);
  endfunction

  function automatic result_t map_sample(sample_t s);
    result_t r;
    longint x, y;
    longint unsigned rad, in8, out8, mag, d;
    x = s.raw_x;
    y = s.raw_y;
    rad = isqrt(longint'(x * x + y * y) << 16);
    in8 = longint'(inner_q) << FRAC_BITS;
    out8 = longint'(outer_q) << FRAC_BITS;
    if (out8 <= in8) begin
      mag = (rad >= out8) ? FS : 0;
      r.zone = (rad >= out8) ? ZONE_FULL : ZONE_DEAD;
    end else if (rad <= in8) begin
      mag = 0;
      r.zone = ZONE_DEAD;
    end else if (rad >= out8) begin
      mag = FS;
      r.zone = ZONE_FULL;
    end else begin
      d = out8 - in8;
      mag = ((rad - in8) * FS * 2 + d) / (2 * d);
      if (mag > FS) mag = FS;
      r.zone = ZONE_LINEAR;
    end
    if (rad == 0) begin
      r.corrected_x = '0;
      r.corrected_y = '0;
    end else begin
      r.corrected_x = scale_axis(x, mag, rad);
      r.corrected_y = scale_axis(y, mag, rad);
    end
    r.corrected_magnitude = SAMPLE_BITS'(mag);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  assign pending = mapped_q.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      inner_q <= '0;
      outer_q <= SAMPLE_BITS'(FS);
      mapped_q.delete();
      errors = 0;
    end else begin
      if (sample_valid && sample_ready) mapped_q.push_back(map_sample(sample));
      if (cfg_we) begin
        if (cfg_index == CFG_INNER) inner_q <= cfg_data;
        else if (cfg_index == CFG_OUTER) outer_q <= cfg_data;
      end
      if (result_valid && result_ready) begin
        if (mapped_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = mapped_q.pop_front();
          if (result.corrected_x !== want.corrected_x)
            report_mismatch("corrected_x", result.corrected_x, want.corrected_x);
          if (result.corrected_y !== want.corrected_y)
            report_mismatch("corrected_y", result.corrected_y, want.corrected_y);
          if (result.corrected_magnitude !== want.corrected_magnitude)
            report_mismatch("magnitude", result.corrected_magnitude,
                            want.corrected_magnitude);
          if (result.zone !== want.zone) report_mismatch("zone", result.zone, want.zone);
        end
      end
    end
  end
endmodule

[test/radial_dead_zone_mapper_tb.sv]
// ----------------------------------------------------------------------------
// radial_dead_zone_mapper_tb
// Drives directed and random stick samples under several threshold settings
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module radial_dead_zone_mapper_tb;
  import rdzm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 63;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [15:0] INNER_SET [6] = '{16'd0, 16'd3000, 16'd16384, 16'd0, 16'd20000,
                                            16'hffff};
  localparam logic [15:0] OUTER_SET [6] = '{16'd32768, 16'd28000, 16'd16384, 16'd46341,
                                            16'd10000, 16'hffff};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  sample_t sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_INNER;
  logic [SAMPLE_BITS-1:0] cfg_data = '0;
  int errors, pending;
  int send_idle = 0, recv_idle = 0;
  int idle_cycles = 0;
  int words_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  radial_dead_zone_mapper i_dut (.*);

  radial_dead_zone_mapper_checker i_checker (.*);

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (result_valid && result_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls at random, rate set by recv_idle percent
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle);
  end

  // one sample word; idles first at random, then holds valid until accepted
  // valid stays high on return, the caller sends again or drops it at once
  task automatic send_word(logic signed [15:0] x, logic signed [15:0] y);
    while ($urandom_range(99) < send_idle) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample.raw_x <= x;
    sample.raw_y <= y;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // wait until the pipe has drained, then let the latency pass
  task automatic drain_pipe();
    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_thresholds(logic [15:0] inner, logic [15:0] outer);
    drain_pipe();
    cfg_we <= 1'b1;
    cfg_index <= CFG_INNER;
    cfg_data <= inner;
    @(negedge clk);
    cfg_index <= CFG_OUTER;
    cfg_data <= outer;
    @(negedge clk);
    // index beyond the two registers must be ignored
    cfg_index <= '1;
    cfg_data <= 16'h1234;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly random angles, some radii near the thresholds
  task automatic send_random(int n, logic [15:0] inner, logic [15:0] outer);
    int pick;
    logic signed [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      x = 16'($urandom);
      y = 16'($urandom);
      if (pick < 3) begin
        // along an axis near a threshold radius
        x = signed'(16'(((pick == 0) ? inner : outer) + $urandom_range(4) - 2));
        y = 16'($urandom_range(3)) - 16'sd1;
        if ($urandom_range(1)) x = -x;
      end else if (pick == 3) begin
        x = 16'($urandom_range(255)) - 16'sd128;
        y = 16'($urandom_range(255)) - 16'sd128;
      end
      send_word(x, y);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at reset thresholds
    send_idle = 8;
    recv_idle = 52;
    send_word(16'sd0, 16'sd0);
    send_word(16'h7fff, 16'sd0);
    send_word(16'h8000, 16'sd0);
    send_word(16'sd0, 16'h8000);
    send_word(16'h8000, 16'h8000);
    send_word(16'h7fff, 16'h7fff);
    send_word(16'h7fff, 16'h8000);
    send_word(16'sd1, 16'sd0);
    send_word(-16'sd1, -16'sd1);
    send_word(16'sd23170, 16'sd23170);
    send_word(16'sd16384, -16'sd16384);
    write_thresholds(16'd32768, 16'd32768);
    send_word(16'h7fff, 16'sd0);
    send_word(16'h8000, 16'sd0);
    send_word(16'sd0, 16'sd0);
    write_thresholds(16'd1000, 16'd500);
    send_word(16'sd499, 16'sd0);
    send_word(16'sd500, 16'sd0);
    send_word(16'sd0, 16'sd0);
    write_thresholds(16'd0, 16'd0);
    send_word(16'sd0, 16'sd0);
    send_word(16'sd1, 16'sd1);

    // random phases over several threshold settings
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle = 52;
        recv_idle = 8;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_thresholds(INNER_SET[p], OUTER_SET[p]);
      send_random(330, INNER_SET[p], OUTER_SET[p]);
    end

    drain_pipe();
    $display("sent %0d sample words over 10 threshold settings", words_sent);
    $display("covered dead, linear and full zones, inverted and equal thresholds");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
